// ----- design/qrs_pkg.sv -----
package qrs_pkg;

    // width of each result value
    localparam int OUT_W = 18;

    // control bits that travel down the pipeline with each request
    typedef struct packed {
        logic valid;
        logic degen;
        logic negd;
    } qrs_ctrl_t;

endpackage

// ----- design/qrs_div_pipe.sv -----
module qrs_div_pipe #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 17
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    // one quotient bit per stage, restoring division
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // bring down next numerator bit, try the subtract
        always_comb begin
            trial    = {rem_in, nq_in[NUM_W-1]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next  = {nq_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ----- design/quadratic_root_solver_top.sv -----
// throughput: one request per cycle; the pipeline moves as a whole and holds when the
// result register is full and not taken
// depth is set by the square root (one root bit per stage) and the two dividers
// (one quotient bit per stage); reset clears only the control bits (valid, degen, negd)
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_a,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_b,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_c,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qrs_pkg::OUT_W-1:0]  m_first_value,
    output logic signed [qrs_pkg::OUT_W-1:0]  m_second_value,
    output logic                              m_is_complex,
    output logic                              m_degenerate
);

    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int PW  = 2 * W;          // product width
    localparam int DW  = 2 * W + 1;      // discriminant magnitude width
    localparam int SW  = W + 1;          // root width
    localparam int XW  = 2 * SW;         // radicand width
    localparam int RW  = SW + 2;         // root remainder width
    localparam int NW  = W + 2;          // numerator magnitude width
    localparam int DNW = W + 1;          // denominator magnitude width
    localparam int NSW = W + 3;          // signed numerator width
    localparam int QSW = NW + 1;         // signed quotient width
    localparam int EW  = (QSW > OUT_W) ? QSW : OUT_W;

    logic en;

    // whole pipeline advances unless a result is stuck at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: magnitudes and products
    logic [W-1:0]        mag_a, mag_b, mag_c;
    logic                n4ac_next;
    qrs_ctrl_t           p1_ctrl_reg;
    logic [PW-1:0]       bb_reg, ac_reg;
    logic                n4ac_reg;
    logic signed [W-1:0] a1_reg, b1_reg;

    always_comb begin
        mag_a     = s_coef_a[W-1] ? $unsigned(-s_coef_a) : $unsigned(s_coef_a);
        mag_b     = s_coef_b[W-1] ? $unsigned(-s_coef_b) : $unsigned(s_coef_b);
        mag_c     = s_coef_c[W-1] ? $unsigned(-s_coef_c) : $unsigned(s_coef_c);
        n4ac_next = (s_coef_c != '0) && (s_coef_a[W-1] != s_coef_c[W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_ctrl_reg <= '0;
        end else if (en) begin
            p1_ctrl_reg.valid <= s_valid;
            p1_ctrl_reg.degen <= (s_coef_a == '0);
            p1_ctrl_reg.negd  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg   <= PW'(mag_b) * PW'(mag_b);
            ac_reg   <= PW'(mag_a) * PW'(mag_c);
            n4ac_reg <= n4ac_next;
            a1_reg   <= s_coef_a;
            b1_reg   <= s_coef_b;
        end
    end

    // stage 2: discriminant magnitude and sign
    logic [PW+1:0]       q4, bb_x, sum4, diff4, rdiff4;
    logic [DW-1:0]       d_next;
    logic                negd_next;
    qrs_ctrl_t           p2_ctrl_reg;
    logic [DW-1:0]       d_reg;
    logic signed [W-1:0] a2_reg, b2_reg;

    always_comb begin
        q4        = {ac_reg, 2'b00};
        bb_x      = (PW + 2)'(bb_reg);
        sum4      = bb_x + q4;
        diff4     = bb_x - q4;
        rdiff4    = q4 - bb_x;
        negd_next = !n4ac_reg && diff4[PW+1];
        if (n4ac_reg) begin
            d_next = sum4[DW-1:0];
        end else if (diff4[PW+1]) begin
            d_next = rdiff4[DW-1:0];
        end else begin
            d_next = diff4[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_ctrl_reg <= '0;
        end else if (en) begin
            p2_ctrl_reg.valid <= p1_ctrl_reg.valid;
            p2_ctrl_reg.degen <= p1_ctrl_reg.degen;
            p2_ctrl_reg.negd  <= negd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= d_next;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
    end

    // square root, one root bit per stage
    logic [XW-1:0]       sq_x_reg    [SW];
    logic [RW-1:0]       sq_rem_reg  [SW];
    logic [SW-1:0]       sq_root_reg [SW];
    logic signed [W-1:0] sq_a_reg    [SW];
    logic signed [W-1:0] sq_b_reg    [SW];
    qrs_ctrl_t           sq_ctrl_reg [SW];

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [XW-1:0]       x_in;
        logic [RW-1:0]       rem_in;
        logic [SW-1:0]       root_in;
        logic signed [W-1:0] a_in, b_in;
        qrs_ctrl_t           ctrl_in;
        logic [RW-1:0]       rem_sh, trial, rem_next;
        logic                ge;
        logic [SW-1:0]       root_next;
        logic [XW-1:0]       x_next;

        if (k == 0) begin : g_first
            assign x_in    = XW'(d_reg);
            assign rem_in  = '0;
            assign root_in = '0;
            assign a_in    = a2_reg;
            assign b_in    = b2_reg;
            assign ctrl_in = p2_ctrl_reg;
        end else begin : g_rest
            assign x_in    = sq_x_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign a_in    = sq_a_reg[k-1];
            assign b_in    = sq_b_reg[k-1];
            assign ctrl_in = sq_ctrl_reg[k-1];
        end

        // bring down two radicand bits and test root bit
        always_comb begin
            rem_sh    = {rem_in[RW-3:0], x_in[XW-1:XW-2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[SW-2:0], ge};
            x_next    = {x_in[XW-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_ctrl_reg[k] <= '0;
            end else if (en) begin
                sq_ctrl_reg[k] <= ctrl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_x_reg[k]    <= x_next;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_a_reg[k]    <= a_in;
                sq_b_reg[k]    <= b_in;
            end
        end
    end

    // numerator stage: pick numerators, split into sign and magnitude
    logic signed [NSW-1:0] b_n, s_n, n1_next, n2_next;
    logic [W-1:0]          mag_a3;
    logic signed [W-1:0]   a_s;
    qrs_ctrl_t             p3_ctrl_reg;
    logic [NW-1:0]         nm1_reg, nm2_reg;
    logic [DNW-1:0]        den_reg;
    logic                  qn1_reg, qn2_reg;

    always_comb begin
        a_s    = sq_a_reg[SW-1];
        b_n    = NSW'(sq_b_reg[SW-1]);
        s_n    = $signed({2'b00, sq_root_reg[SW-1]});
        mag_a3 = a_s[W-1] ? $unsigned(-a_s) : $unsigned(a_s);
        if (sq_ctrl_reg[SW-1].negd) begin
            n1_next = -b_n;
            n2_next = s_n;
        end else begin
            n1_next = s_n - b_n;
            n2_next = -b_n - s_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_ctrl_reg <= '0;
        end else if (en) begin
            p3_ctrl_reg <= sq_ctrl_reg[SW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm1_reg <= n1_next[NSW-1] ? NW'(-n1_next) : NW'(n1_next);
            nm2_reg <= n2_next[NSW-1] ? NW'(-n2_next) : NW'(n2_next);
            den_reg <= {mag_a3, 1'b0};
            qn1_reg <= n1_next[NSW-1] ^ a_s[W-1];
            qn2_reg <= n2_next[NSW-1] ^ a_s[W-1];
        end
    end

    // two dividers share the denominator
    logic [NW-1:0] quo1, quo2;

    qrs_div_pipe #(
        .NUM_W (NW),
        .DEN_W (DNW)
    ) u_div_first (
        .aclk (aclk),
        .en   (en),
        .num  (nm1_reg),
        .den  (den_reg),
        .quo  (quo1)
    );

    qrs_div_pipe #(
        .NUM_W (NW),
        .DEN_W (DNW)
    ) u_div_second (
        .aclk (aclk),
        .en   (en),
        .num  (nm2_reg),
        .den  (den_reg),
        .quo  (quo2)
    );

    // control and quotient signs ride alongside the dividers
    qrs_ctrl_t dv_ctrl_reg [NW];
    logic      dv_qn1_reg  [NW];
    logic      dv_qn2_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_dv
        qrs_ctrl_t ctrl_in;
        logic      qn1_in, qn2_in;

        if (k == 0) begin : g_first
            assign ctrl_in = p3_ctrl_reg;
            assign qn1_in  = qn1_reg;
            assign qn2_in  = qn2_reg;
        end else begin : g_rest
            assign ctrl_in = dv_ctrl_reg[k-1];
            assign qn1_in  = dv_qn1_reg[k-1];
            assign qn2_in  = dv_qn2_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_ctrl_reg[k] <= '0;
            end else if (en) begin
                dv_ctrl_reg[k] <= ctrl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_qn1_reg[k] <= qn1_in;
                dv_qn2_reg[k] <= qn2_in;
            end
        end
    end

    // output stage: apply sign, saturate, clear on degenerate
    logic signed [QSW-1:0] sq1, sq2;
    logic signed [EW-1:0]  e1, e2, hi_lim, lo_lim;
    logic signed [OUT_W-1:0] first_next, second_next;
    qrs_ctrl_t             last_ctrl;
    logic                  m_valid_reg, m_is_complex_reg, m_degenerate_reg;
    logic signed [OUT_W-1:0] m_first_reg, m_second_reg;

    always_comb begin
        last_ctrl = dv_ctrl_reg[NW-1];
        hi_lim    = EW'($signed({1'b0, {(OUT_W - 1){1'b1}}}));
        lo_lim    = EW'($signed({1'b1, {(OUT_W - 1){1'b0}}}));
        sq1       = dv_qn1_reg[NW-1] ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
        sq2       = dv_qn2_reg[NW-1] ? -$signed({1'b0, quo2}) : $signed({1'b0, quo2});
        e1        = EW'(sq1);
        e2        = EW'(sq2);
        if (e1 > hi_lim) begin
            e1 = hi_lim;
        end else if (e1 < lo_lim) begin
            e1 = lo_lim;
        end
        if (e2 > hi_lim) begin
            e2 = hi_lim;
        end else if (e2 < lo_lim) begin
            e2 = lo_lim;
        end
        first_next  = last_ctrl.degen ? '0 : e1[OUT_W-1:0];
        second_next = last_ctrl.degen ? '0 : e2[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_first_reg      <= first_next;
            m_second_reg     <= second_next;
            m_is_complex_reg <= last_ctrl.negd && !last_ctrl.degen;
            m_degenerate_reg <= last_ctrl.degen;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_value  = m_first_reg;
    assign m_second_value = m_second_reg;
    assign m_is_complex   = m_is_complex_reg;
    assign m_degenerate   = m_degenerate_reg;

    // degenerate result carries zero values and no complex flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_first_value == '0 && m_second_value == '0
            && !m_is_complex)
        else $error("degenerate result with nonzero payload");

    // an accepted request shows up in the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> p1_ctrl_reg.valid)
        else $error("accepted request lost at first stage");

    // a stall freezes the valid bit of the last divider stage control
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(last_ctrl.valid))
        else $error("pipeline moved during stall");

endmodule
